@@ sv/tlvrf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlvrf_pkg
// Shared types and constants for the record finder: scan phases, header
// layout and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvrf_pkg;

   // field widths
   localparam int DATA_W   = 8;
   localparam int WORD_W   = 32;
   localparam int OFFSET_W = 16;

   // record header layout: 4-byte id, then 4-byte length, little endian
   localparam int FIELD_BYTES = 4;
   localparam int HDR_BYTES   = 8;
   localparam int HCNT_W      = 3;

   localparam logic [HCNT_W-1:0] ID_LAST_IDX  = HCNT_W'(FIELD_BYTES - 1);
   localparam logic [HCNT_W-1:0] HDR_LAST_IDX = HCNT_W'(HDR_BYTES - 1);

   // scan phase of the record walker
   typedef enum logic [1:0] {
      PHASE_ID   = 2'd0,
      PHASE_LEN  = 2'd1,
      PHASE_SKIP = 2'd2,
      PHASE_DONE = 2'd3
   } phase_type;

endpackage

`default_nettype wire

@@ sv/tlv_record_finder_core.sv @@
// ----------------------------------------------------------------------------
// tlv_record_finder_core
// Streaming lookup of one record in a buffer of id/length/value records.
// ----------------------------------------------------------------------------
// Usage:
//   The buffer enters one byte per transfer on the req_ channel, with
//   req_last_byte high on its final byte. Each record is a 4-byte
//   little-endian id, a 4-byte little-endian length and the value bytes.
//   The first record whose id equals the target register is reported.
//   One result per buffer leaves on the rsp_ channel: found flag, value
//   length (0 when the value runs past the buffer end), value offset and
//   an overflow flag for buffers longer than MAX_BUFFER_BYTES.
//   The target is written through csr_wr_en / csr_wr_data while idle.
//   Throughput is one byte per cycle while req_ready stays high; the
//   result is registered: the last byte is captured in the input
//   register at its transfer, then passes the snapshot stage and the
//   result register.
//   A stalled receiver holds the result; bytes not marked last keep
//   flowing, and one further buffer end can be held in the snapshot stage
//   before req_ready drops.
//   Reset clears the scan state and the target id to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_record_finder_core #(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration
   input  wire logic                              csr_wr_en,
   input  wire logic [tlvrf_pkg::WORD_W-1:0]      csr_wr_data,
   // byte stream
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tlvrf_pkg::DATA_W-1:0]      req_data_byte,
   input  wire logic                              req_last_byte,
   // result
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_found,
   output logic [tlvrf_pkg::WORD_W-1:0]           rsp_value_length,
   output logic [tlvrf_pkg::OFFSET_W-1:0]         rsp_value_offset,
   output logic                                   rsp_overflow
);

   localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 2);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BUFFER_BYTES);

   logic [tlvrf_pkg::WORD_W-1:0]   target_ff;

   logic                           fin_valid;
   logic                           fin_ready;
   logic                           fin_match;
   logic [tlvrf_pkg::WORD_W-1:0]   fin_length;
   logic [POS_W-1:0]               fin_offset;
   logic [POS_W-1:0]               fin_position;

   logic                           rsp_valid_ff;
   logic                           found_ff, found_in;
   logic [tlvrf_pkg::WORD_W-1:0]   length_ff, length_in;
   logic [tlvrf_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic                           overflow_ff, overflow_in;

   logic [tlvrf_pkg::WORD_W:0]     value_end;
   logic [POS_W+tlvrf_pkg::OFFSET_W-1:0] offset_ext;

   // target id register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // record walker
   tlvrf_scan #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .target_id     (target_ff),
      .fin_valid     (fin_valid),
      .fin_ready     (fin_ready),
      .fin_match     (fin_match),
      .fin_length    (fin_length),
      .fin_offset    (fin_offset),
      .fin_position  (fin_position)
   );

   // result formatting: truncation check and overflow masking
   assign value_end  = {1'b0, fin_length} + (tlvrf_pkg::WORD_W + 1)'(fin_offset);
   assign offset_ext = {{tlvrf_pkg::OFFSET_W{1'b0}}, fin_offset};

   always_comb begin
      overflow_in = fin_position > POS_LIMIT;
      found_in    = 1'b0;
      length_in   = '0;
      offset_in   = '0;
      if (!overflow_in && fin_match) begin
         found_in  = 1'b1;
         length_in = (value_end > (tlvrf_pkg::WORD_W + 1)'(fin_position)) ? '0 : fin_length;
         offset_in = offset_ext[tlvrf_pkg::OFFSET_W-1:0];
      end
   end

   // result register
   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_valid && fin_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fin_valid && fin_ready) begin
         found_ff    <= found_in;
         length_ff   <= length_in;
         offset_ff   <= offset_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_value_length = length_ff;
   assign rsp_value_offset = offset_ff;
   assign rsp_overflow     = overflow_ff;

   // an overflowed buffer reports nothing else
   a_overflow_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         !rsp_found && rsp_value_length == '0 && rsp_value_offset == '0)
      else $error("overflow result carries match data");

   // no match means no length
   a_nomatch_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_value_length == '0)
      else $error("length reported without a match");

   // a blocked snapshot keeps its contents
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      fin_valid && !fin_ready |=>
         fin_valid && $stable(fin_position) && $stable(fin_match))
      else $error("snapshot changed while blocked");

endmodule

`default_nettype wire

@@ sv/tlvrf_scan.sv @@
// ----------------------------------------------------------------------------
// tlvrf_scan
// Input register and record walker. Assembles headers, skips values of
// records that do not match and hands a snapshot of the scan to the result
// stage on the last byte of each buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvrf_scan #(
   parameter int MAX_BUFFER_BYTES = 65536,
   localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 2)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // byte stream
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [tlvrf_pkg::DATA_W-1:0]   req_data_byte,
   input  wire logic                           req_last_byte,
   // search key
   input  wire logic [tlvrf_pkg::WORD_W-1:0]   target_id,
   // end-of-buffer snapshot
   output logic                                fin_valid,
   input  wire logic                           fin_ready,
   output logic                                fin_match,
   output logic [tlvrf_pkg::WORD_W-1:0]        fin_length,
   output logic [POS_W-1:0]                    fin_offset,
   output logic [POS_W-1:0]                    fin_position
);

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BUFFER_BYTES);
   localparam logic [POS_W-1:0] POS_SAT   = POS_W'(MAX_BUFFER_BYTES + 1);

   // input register
   logic                           in_valid_ff;
   logic [tlvrf_pkg::DATA_W-1:0]   in_data_ff;
   logic                           in_last_ff;

   // scan state
   tlvrf_pkg::phase_type           phase_ff, phase_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [tlvrf_pkg::HCNT_W-1:0]   hcnt_ff, hcnt_in;
   logic [tlvrf_pkg::WORD_W-1:0]   id_ff, id_in;
   logic [tlvrf_pkg::WORD_W-1:0]   len_ff, len_in;
   logic [tlvrf_pkg::WORD_W-1:0]   skip_ff, skip_in;
   logic                           match_ff, match_in;
   logic [tlvrf_pkg::WORD_W-1:0]   mlen_ff, mlen_in;
   logic [POS_W-1:0]               moff_ff, moff_in;

   // snapshot register
   logic                           fin_valid_ff;
   logic                           fin_match_ff;
   logic [tlvrf_pkg::WORD_W-1:0]   fin_length_ff;
   logic [POS_W-1:0]               fin_offset_ff;
   logic [POS_W-1:0]               fin_position_ff;

   logic                           fin_free;
   logic                           step;
   logic                           scan_en;
   logic                           hdr_done;
   logic                           id_hit;
   logic [tlvrf_pkg::WORD_W-1:0]   len_full;

   // a last byte needs a free snapshot slot, other bytes always advance
   assign fin_free  = !fin_valid_ff || fin_ready;
   assign step      = in_valid_ff && (!in_last_ff || fin_free);
   assign req_ready = !in_valid_ff || step;

   // bytes past the limit are not scanned; the position saturates past the limit
   assign scan_en  = pos_ff < POS_LIMIT;
   assign pos_in   = scan_en ? (pos_ff + POS_W'(1)) : POS_SAT;

   // header completion and id compare
   assign hdr_done = ((phase_ff == tlvrf_pkg::PHASE_ID) || (phase_ff == tlvrf_pkg::PHASE_LEN))
                     && (hcnt_ff == tlvrf_pkg::HDR_LAST_IDX);
   assign len_full = {in_data_ff, len_ff[tlvrf_pkg::WORD_W-1:tlvrf_pkg::DATA_W]};
   assign id_hit   = id_ff == target_id;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (scan_en) begin
         case (phase_ff)
            tlvrf_pkg::PHASE_ID,
            tlvrf_pkg::PHASE_LEN: begin
               if (hcnt_ff == tlvrf_pkg::ID_LAST_IDX) begin
                  phase_in = tlvrf_pkg::PHASE_LEN;
               end else if (hdr_done) begin
                  if (id_hit) begin
                     phase_in = tlvrf_pkg::PHASE_DONE;
                  end else if (len_full == '0) begin
                     phase_in = tlvrf_pkg::PHASE_ID;
                  end else begin
                     phase_in = tlvrf_pkg::PHASE_SKIP;
                  end
               end
            end
            tlvrf_pkg::PHASE_SKIP: begin
               if (skip_ff == tlvrf_pkg::WORD_W'(1)) begin
                  phase_in = tlvrf_pkg::PHASE_ID;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // header gather, skip count and match capture
   always_comb begin
      hcnt_in  = hcnt_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      skip_in  = skip_ff;
      match_in = match_ff;
      mlen_in  = mlen_ff;
      moff_in  = moff_ff;
      if (scan_en) begin
         case (phase_ff)
            tlvrf_pkg::PHASE_ID,
            tlvrf_pkg::PHASE_LEN: begin
               hcnt_in = hcnt_ff + tlvrf_pkg::HCNT_W'(1);
               if (hcnt_ff <= tlvrf_pkg::ID_LAST_IDX) begin
                  id_in = {in_data_ff, id_ff[tlvrf_pkg::WORD_W-1:tlvrf_pkg::DATA_W]};
               end else begin
                  len_in = len_full;
               end
               if (hdr_done) begin
                  if (id_hit) begin
                     match_in = 1'b1;
                     mlen_in  = len_full;
                     moff_in  = pos_in;
                  end else begin
                     skip_in  = len_full;
                  end
               end
            end
            tlvrf_pkg::PHASE_SKIP: begin
               skip_in = skip_ff - tlvrf_pkg::WORD_W'(1);
            end
            default: begin
               skip_in = skip_ff;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // scan state, cleared after the last byte of a buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tlvrf_pkg::PHASE_ID;
         pos_ff   <= '0;
         hcnt_ff  <= '0;
         match_ff <= 1'b0;
      end else if (step) begin
         if (in_last_ff) begin
            phase_ff <= tlvrf_pkg::PHASE_ID;
            pos_ff   <= '0;
            hcnt_ff  <= '0;
            match_ff <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            hcnt_ff  <= hcnt_in;
            match_ff <= match_in;
         end
      end
      if (step) begin
         id_ff   <= id_in;
         len_ff  <= len_in;
         skip_ff <= skip_in;
         mlen_ff <= mlen_in;
         moff_ff <= moff_in;
      end
   end

   // end-of-buffer snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         fin_valid_ff <= 1'b1;
      end else if (fin_ready) begin
         fin_valid_ff <= 1'b0;
      end
      if (step && in_last_ff) begin
         fin_match_ff    <= match_in;
         fin_length_ff   <= mlen_in;
         fin_offset_ff   <= moff_in;
         fin_position_ff <= pos_in;
      end
   end

   assign fin_valid    = fin_valid_ff;
   assign fin_match    = fin_match_ff;
   assign fin_length   = fin_length_ff;
   assign fin_offset   = fin_offset_ff;
   assign fin_position = fin_position_ff;

endmodule

`default_nettype wire

@@ bench/tlv_record_finder_core_tb.sv @@
// ----------------------------------------------------------------------------
// tlv_record_finder_core_tb
// Self-checking bench for the record finder. A table of directed buffers
// covers the corner cases: reset target, short headers, truncated values,
// skipped records, the position limit and the 16-bit offset wrap. Random
// buffers of well-formed records with random content follow, plus some
// noise and cut-off buffers. Results are checked against an in-bench scan model
// or a typed row's table entry, with random byte gaps and random result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_record_finder_core_tb;

   localparam int MAX_BYTES      = 65536;
   localparam int RANDOM_BYTES   = 1950;
   localparam int QUIET_CYCLES   = 4;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SHOWN_ERRORS   = 10;

   typedef struct packed {
      logic                                 found;
      logic [tlvrf_pkg::WORD_W-1:0]         len;
      logic [tlvrf_pkg::OFFSET_W-1:0]       off;
      logic                                 ovf;
   } lookup_res_type;

   localparam lookup_res_type NO_HIT = '0;

   // one directed buffer: optional leading record, then the record of interest
   typedef struct {
      logic [tlvrf_pkg::WORD_W-1:0] target;
      bit                           pre_en;
      logic [tlvrf_pkg::WORD_W-1:0] pre_id;
      logic [tlvrf_pkg::WORD_W-1:0] pre_len;
      logic [tlvrf_pkg::WORD_W-1:0] rec_id;
      logic [tlvrf_pkg::WORD_W-1:0] rec_len;
      int                           nbytes;
      bit                           typed;
      lookup_res_type               want;
   } buf_row_type;

   logic                           clock;
   logic                           reset         = 1'b1;
   logic                           csr_wr_en     = 1'b0;
   logic [tlvrf_pkg::WORD_W-1:0]   csr_wr_data   = '0;
   logic                           req_valid     = 1'b0;
   logic                           req_ready;
   logic [tlvrf_pkg::DATA_W-1:0]   req_data_byte = '0;
   logic                           req_last_byte = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready     = 1'b0;
   logic                           rsp_found;
   logic [tlvrf_pkg::WORD_W-1:0]   rsp_value_length;
   logic [tlvrf_pkg::OFFSET_W-1:0] rsp_value_offset;
   logic                           rsp_overflow;

   // scan model state
   logic [tlvrf_pkg::WORD_W-1:0]   target_reg;
   logic [16:0]                    pos;
   tlvrf_pkg::phase_type           scan_ph;
   logic [tlvrf_pkg::HCNT_W-1:0]   hcnt;
   logic [tlvrf_pkg::WORD_W-1:0]   id_acc;
   logic [tlvrf_pkg::WORD_W-1:0]   len_acc;
   logic [tlvrf_pkg::WORD_W-1:0]   skip_cnt;
   logic                           hit;
   logic [tlvrf_pkg::WORD_W-1:0]   hit_len;
   logic [16:0]                    hit_off;

   lookup_res_type      pending_lookups[$];
   bit                  typed_on      = 1'b0;
   lookup_res_type      typed_res     = '0;
   int                  send_idle_pct = 0;
   int                  rsp_idle_pct  = 0;
   int                  rsp_stall     = 0;
   int                  bad_results   = 0;
   int                  quiet_cycles  = 0;

   tlv_record_finder_core #(
      .MAX_BUFFER_BYTES(MAX_BYTES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_value_length(rsp_value_length),
      .rsp_value_offset(rsp_value_offset),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // clear per-buffer scan state
   function automatic void clear_scan_model();
      pos      = '0;
      scan_ph  = tlvrf_pkg::PHASE_ID;
      hcnt     = '0;
      id_acc   = '0;
      len_acc  = '0;
      skip_cnt = '0;
      hit      = 1'b0;
      hit_len  = '0;
      hit_off  = '0;
   endfunction

   // advance the scan by one byte; returns 1 with the lookup result on a last byte
   function automatic bit lookup_byte(input logic [tlvrf_pkg::DATA_W-1:0] d,
                                      input logic last,
                                      output lookup_res_type r);
      r = '0;
      if (pos < MAX_BYTES) begin
         pos++;
         case (scan_ph)
            tlvrf_pkg::PHASE_ID, tlvrf_pkg::PHASE_LEN: begin
               if (hcnt <= tlvrf_pkg::ID_LAST_IDX)
                  id_acc = {d, id_acc[tlvrf_pkg::WORD_W-1:8]};
               else
                  len_acc = {d, len_acc[tlvrf_pkg::WORD_W-1:8]};
               if (hcnt == tlvrf_pkg::ID_LAST_IDX) begin
                  scan_ph = tlvrf_pkg::PHASE_LEN;
                  hcnt++;
               end else if (hcnt == tlvrf_pkg::HDR_LAST_IDX) begin
                  hcnt = '0;
                  if (id_acc == target_reg) begin
                     hit     = 1'b1;
                     hit_len = len_acc;
                     hit_off = pos;
                     scan_ph = tlvrf_pkg::PHASE_DONE;
                  end else if (len_acc == '0) begin
                     scan_ph = tlvrf_pkg::PHASE_ID;
                  end else begin
                     skip_cnt = len_acc;
                     scan_ph  = tlvrf_pkg::PHASE_SKIP;
                  end
               end else begin
                  hcnt++;
               end
            end
            tlvrf_pkg::PHASE_SKIP: begin
               skip_cnt--;
               if (skip_cnt == '0) scan_ph = tlvrf_pkg::PHASE_ID;
            end
            default: ;
         endcase
      end else begin
         pos = 17'(MAX_BYTES + 1);
      end
      if (!last) return 1'b0;
      r.ovf = (pos > MAX_BYTES);
      if (!r.ovf && hit) begin
         r.found = 1'b1;
         r.len   = (longint'(hit_off) + longint'(hit_len) > longint'(pos)) ? '0 : hit_len;
         r.off   = hit_off[tlvrf_pkg::OFFSET_W-1:0];
      end
      clear_scan_model();
      return 1'b1;
   endfunction

   // idle length: mostly none, sometimes short, rarely long
   function automatic int gap_len(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic buf_row_type dir_row(input logic [tlvrf_pkg::WORD_W-1:0] target,
                                           input bit pre_en,
                                           input logic [tlvrf_pkg::WORD_W-1:0] pre_id,
                                           pre_len,
                                           input logic [tlvrf_pkg::WORD_W-1:0] rec_id,
                                           rec_len,
                                           input int nbytes, input bit typed,
                                           input lookup_res_type want);
      buf_row_type row;
      row.target  = target;
      row.pre_en  = pre_en;
      row.pre_id  = pre_id;
      row.pre_len = pre_len;
      row.rec_id  = rec_id;
      row.rec_len = rec_len;
      row.nbytes  = nbytes;
      row.typed   = typed;
      row.want    = want;
      return row;
   endfunction

   // little-endian header followed by nval random value bytes
   task automatic add_record(ref logic [tlvrf_pkg::DATA_W-1:0] q[$],
                             input logic [tlvrf_pkg::WORD_W-1:0] id,
                             input logic [tlvrf_pkg::WORD_W-1:0] len, input longint nval);
      for (int k = 0; k < tlvrf_pkg::FIELD_BYTES; k++) q.push_back(id[8*k +: 8]);
      for (int k = 0; k < tlvrf_pkg::FIELD_BYTES; k++) q.push_back(len[8*k +: 8]);
      for (longint k = 0; k < nval; k++) q.push_back(8'($urandom));
   endtask

   // random buffer: mostly record sequences, some noise, some cut short
   task automatic make_random_buffer(ref logic [tlvrf_pkg::DATA_W-1:0] q[$]);
      int                           nrec;
      int                           cut;
      logic [tlvrf_pkg::WORD_W-1:0] id;
      logic [tlvrf_pkg::WORD_W-1:0] len;
      longint                       nval;
      q.delete();
      if ($urandom_range(0, 9) < 2) begin
         repeat ($urandom_range(1, 24)) q.push_back(8'($urandom));
      end else begin
         nrec = $urandom_range(1, 4);
         repeat (nrec) begin
            case ($urandom_range(0, 7))
               0, 1, 2: id = target_reg;
               3:       id = target_reg ^ (32'd1 << $urandom_range(0, 31));
               4:       id = {<<8{target_reg}};
               default: id = $urandom;
            endcase
            case ($urandom_range(0, 15))
               10, 11, 12: len = $urandom_range(9, 40);
               13, 14:     len = {24'hFF_FFFF, 8'($urandom)};
               15:         len = $urandom;
               default:    len = $urandom_range(0, 8);
            endcase
            nval = (len <= 40) ? longint'(len) : longint'($urandom_range(0, 6));
            add_record(q, id, len, nval);
         end
         case ($urandom_range(0, 9))
            6, 7: repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
            8, 9: begin
               cut = $urandom_range(1, q.size());
               while (q.size() > cut) void'(q.pop_back());
            end
            default: ;
         endcase
      end
   endtask

   // one byte transfer, with an optional gap before it
   task automatic send_byte(input logic [tlvrf_pkg::DATA_W-1:0] d, input logic last);
      lookup_res_type r;
      int             g;
      g = gap_len(send_idle_pct);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (lookup_byte(d, last, r)) begin
         if (typed_on) r = typed_res;
         pending_lookups.push_back(r);
      end
   endtask

   task automatic send_buffer(ref logic [tlvrf_pkg::DATA_W-1:0] q[$]);
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   // target write once every result is out and the pipeline has emptied
   task automatic set_target(input logic [tlvrf_pkg::WORD_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      target_reg  = v;
   endtask

   task automatic note_bad(input string msg);
      bad_results++;
      if (bad_results <= SHOWN_ERRORS) $display("%s", msg);
   endtask

   // stimulus: directed table, then random phases
   initial begin : stimulus
      buf_row_type                  rows[$];
      logic [tlvrf_pkg::DATA_W-1:0] bytes_q[$];
      int                           sent;
      int                           phase_no;
      target_reg = '0;
      clear_scan_model();

      // reset target, lone last byte
      rows.push_back(dir_row(32'h0, 0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 1, NO_HIT));
      // empty value matches as soon as the header completes
      rows.push_back(dir_row(32'h0, 0, 32'h0, 32'h0, 32'h0, 32'h0, 8, 1,
                             '{1'b1, 32'd0, 16'd8, 1'b0}));
      // all-ones id with a short value
      rows.push_back(dir_row('1, 0, 32'h0, 32'h0, '1, 32'd3, 11, 1,
                             '{1'b1, 32'd3, 16'd8, 1'b0}));
      // lone empty record that does not match
      rows.push_back(dir_row('1, 0, 32'h0, 32'h0, 32'h0, 32'h0, 8, 1, NO_HIT));
      // header cut off inside the length, after one and then after three of its bytes
      rows.push_back(dir_row(32'h1234_5678, 0, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 5, 1,
                             NO_HIT));
      rows.push_back(dir_row(32'h1234_5678, 0, 32'h0, 32'h0, 32'h1234_5678, 32'h0, 7, 1,
                             NO_HIT));
      // skipped value runs past the end
      rows.push_back(dir_row(32'h1234_5678, 0, 32'h0, 32'h0, 32'h8765_4321, 32'd100, 20, 1,
                             NO_HIT));
      // matching value cut short, then an all-ones length with a single value byte
      rows.push_back(dir_row(32'hA5A5_A5A5, 0, 32'h0, 32'h0, 32'hA5A5_A5A5, 32'd10, 15, 1,
                             '{1'b1, 32'd0, 16'd8, 1'b0}));
      rows.push_back(dir_row(32'hA5A5_A5A5, 0, 32'h0, 32'h0, 32'hA5A5_A5A5, '1, 9, 1,
                             '{1'b1, 32'd0, 16'd8, 1'b0}));
      // one record skipped, then the match
      rows.push_back(dir_row(32'hCAFE_F00D, 1, 32'h1, 32'd5, 32'hCAFE_F00D, 32'd2, 23, 1,
                             '{1'b1, 32'd2, 16'd21, 1'b0}));
      // empty record skipped, then the match
      rows.push_back(dir_row(32'hCAFE_F00D, 1, 32'h0, 32'h0, 32'hCAFE_F00D, 32'h0, 16, 0,
                             NO_HIT));
      // bytes after the match are not scanned
      rows.push_back(dir_row(32'h0000_00FF, 0, 32'h0, 32'h0, 32'h0000_00FF, 32'd2, 30, 0,
                             NO_HIT));
      // byte-reversed id must not match
      rows.push_back(dir_row(32'h0102_0304, 0, 32'h0, 32'h0, 32'h0403_0201, 32'h0, 8, 0,
                             NO_HIT));
      // length wider than one byte
      rows.push_back(dir_row(32'h0102_0304, 0, 32'h0, 32'h0, 32'h0102_0304, 32'd256, 264, 0,
                             NO_HIT));
      // skip ends, then the next header is cut off
      rows.push_back(dir_row(32'h0BAD_BEEF, 1, 32'h0, 32'd4, 32'h0BAD_BEEF, 32'h0, 14, 0,
                             NO_HIT));
      // buffer exactly at the position limit
      rows.push_back(dir_row(32'h5EED_0001, 0, 32'h0, 32'h0, 32'h1111_1111, 32'd65528,
                             MAX_BYTES, 1, NO_HIT));
      // one byte over the limit hides an early match
      rows.push_back(dir_row(32'h5EED_0001, 0, 32'h0, 32'h0, 32'h5EED_0001, 32'd4,
                             MAX_BYTES + 1, 1, '{1'b0, 32'd0, 16'd0, 1'b1}));
      // match offset at the limit keeps only its low 16 bits
      rows.push_back(dir_row(32'h5EED_0001, 1, ~32'h5EED_0001, 32'd65520, 32'h5EED_0001,
                             32'h0, MAX_BYTES, 1, '{1'b1, 32'd0, 16'd0, 1'b0}));
      // long noise well past the limit
      rows.push_back(dir_row(32'h5EED_0001, 0, 32'h0, 32'h0, 32'h2222_2222, 32'h00FF_FFFF,
                             MAX_BYTES + 4, 0, NO_HIT));
      // short match right after an overflowed buffer
      rows.push_back(dir_row(32'h5EED_0001, 0, 32'h0, 32'h0, 32'h5EED_0001, 32'd2, 10, 1,
                             '{1'b1, 32'd2, 16'd8, 1'b0}));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table; the first row runs on the reset target
      foreach (rows[i]) begin
         if (i != 0) set_target(rows[i].target);
         bytes_q.delete();
         if (rows[i].pre_en)
            add_record(bytes_q, rows[i].pre_id, rows[i].pre_len,
                       (longint'(rows[i].pre_len) > rows[i].nbytes) ?
                       longint'(rows[i].nbytes) : longint'(rows[i].pre_len));
         add_record(bytes_q, rows[i].rec_id, rows[i].rec_len,
                    (longint'(rows[i].rec_len) > rows[i].nbytes) ?
                    longint'(rows[i].nbytes) : longint'(rows[i].rec_len));
         while (bytes_q.size() < rows[i].nbytes) bytes_q.push_back(8'($urandom));
         while (bytes_q.size() > rows[i].nbytes) void'(bytes_q.pop_back());
         send_idle_pct = (rows[i].nbytes > 1000) ? 0 : 25;
         rsp_idle_pct  = 25;
         typed_on      = rows[i].typed;
         typed_res     = rows[i].want;
         send_buffer(bytes_q);
      end
      typed_on = 1'b0;

      // random phases, each with its own target and idle mix
      sent     = 0;
      phase_no = 0;
      while (sent < RANDOM_BYTES) begin
         case (phase_no % 5)
            0:       set_target('0);
            1:       set_target('1);
            default: set_target($urandom);
         endcase
         send_idle_pct = (phase_no % 3 == 0) ? 0 : $urandom_range(10, 50);
         rsp_idle_pct  = (phase_no % 4 == 1) ? 0 : $urandom_range(10, 60);
         repeat (6) begin
            make_random_buffer(bytes_q);
            sent += bytes_q.size();
            send_buffer(bytes_q);
         end
         phase_no++;
      end

      // drain and verdict
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_results == 0 && pending_lookups.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // result side stalls
   always @(posedge clock) begin : rsp_side
      int g;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         g = gap_len(rsp_idle_pct);
         if (g > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall <= g - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest pending lookup
   always @(posedge clock) begin : rsp_check
      lookup_res_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            note_bad($sformatf("unexpected result: found %0d len %h off %h ovf %0d",
                               rsp_found, rsp_value_length, rsp_value_offset, rsp_overflow));
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_found !== want.found || rsp_value_length !== want.len ||
                rsp_value_offset !== want.off || rsp_overflow !== want.ovf)
               note_bad($sformatf({"mismatch: expected found %0d len %h off %h ovf %0d, ",
                                   "got found %0d len %h off %h ovf %0d"},
                                  want.found, want.len, want.off, want.ovf,
                                  rsp_found, rsp_value_length, rsp_value_offset,
                                  rsp_overflow));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/tlvrf_pkg.sv
sv/tlvrf_scan.sv
sv/tlv_record_finder_core.sv
bench/tlv_record_finder_core_tb.sv
